FILE: design/nsrb_pkg.sv
`default_nettype none

package nsrb_pkg;

  // NTP era and protocol constants
  localparam logic [31:0] EPOCH_OFFSET    = 32'd2208988800;
  localparam logic [31:0] Y2020_NTP       = 32'd3786825600;
  localparam logic [22:0] MS_TO_FRAC      = 23'd4294967;
  localparam logic [10:0] MIN_LEN         = 11'd48;
  localparam logic [2:0]  MODE_SYM_ACTIVE = 3'd1;
  localparam logic [2:0]  MODE_CLIENT     = 3'd3;
  localparam logic [2:0]  MODE_SERVER     = 3'd4;
  localparam logic [2:0]  VN_FLOOR        = 3'd3;
  localparam logic [7:0]  PRECISION       = 8'hF6;

  // Response word positions
  localparam logic [3:0] W_HEADER     = 4'd0;
  localparam logic [3:0] W_ROOT_DELAY = 4'd1;
  localparam logic [3:0] W_ROOT_DISP  = 4'd2;
  localparam logic [3:0] W_REF_ID     = 4'd3;
  localparam logic [3:0] W_REF_SEC    = 4'd4;
  localparam logic [3:0] W_REF_FRAC   = 4'd5;
  localparam logic [3:0] W_ORIG_SEC   = 4'd6;
  localparam logic [3:0] W_ORIG_FRAC  = 4'd7;
  localparam logic [3:0] W_RX_SEC     = 4'd8;
  localparam logic [3:0] W_RX_FRAC    = 4'd9;
  localparam logic [3:0] W_TX_SEC     = 4'd10;
  localparam logic [3:0] W_TX_FRAC    = 4'd11;
  localparam logic [3:0] LAST_IDX     = W_TX_FRAC;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_STRATUM   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_ID    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_SYNC = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISP  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIFT     = 3'd6;

  // Drift scaling: age * ppm * 65536 / 1e6 == (age * ppm * 1024) / 15625
  localparam logic [13:0] DISP_DIVISOR = 14'd15625;
  localparam int PROD_W    = 42;  // age (32) times ppm (10)
  localparam int DIV_BITS  = 6;   // quotient bits resolved per cycle
  localparam int DIV_STEPS = 9;
  localparam int DVD_W     = DIV_BITS * DIV_STEPS;  // 54
  localparam int QUO_W     = 39;  // largest scaled drift fits here
  localparam int SUM_W     = 40;

  typedef struct packed {
    logic [7:0]  stratum;
    logic [31:0] ref_id;
    logic [1:0]  leap;
    logic [31:0] last_sync;
    logic [31:0] min_disp;
    logic [31:0] max_disp;
    logic [9:0]  drift;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  version;
    logic [7:0]  poll;
    logic [31:0] root_disp;
    logic [63:0] orig;
    logic [31:0] rx_ntp;
    logic [31:0] rx_frac;
    logic [31:0] tx_ntp;
    logic [31:0] tx_frac;
  } resp_t;

endpackage

`default_nettype wire

FILE: design/nsrb_front.sv
`default_nettype none

module nsrb_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire nsrb_pkg::cfg_t       cfg,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [10:0]          in_packet_length,
  input  wire logic [7:0]           in_header_byte,
  input  wire logic [7:0]           in_poll_byte,
  input  wire logic [63:0]          in_client_transmit_stamp,
  input  wire logic                 in_time_valid,
  input  wire logic [31:0]          in_rx_seconds,
  input  wire logic [9:0]           in_rx_millis,
  input  wire logic [31:0]          in_tx_seconds,
  input  wire logic [9:0]           in_tx_millis,
  output logic                      push_valid,
  input  wire logic                 push_ready,
  output nsrb_pkg::resp_t           push_data
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MUL  = 4'b0010,
    F_DIV  = 4'b0100,
    F_SUM  = 4'b1000
  } fstate_t;

  fstate_t state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;

  logic        accept;
  logic [31:0] rx_ntp;
  logic [2:0]  mode;
  logic        drop;
  logic [32:0] rx_prod, tx_prod;

  logic [2:0]  version_r, version_in;
  logic [7:0]  poll_r;
  logic [63:0] orig_r;
  logic [31:0] rx_ntp_r, tx_ntp_r, rx_frac_r, tx_frac_r;
  logic [31:0] age_r;
  logic        use_drift_r;

  logic [nsrb_pkg::PROD_W-1:0]   prod;
  logic [nsrb_pkg::DVD_W-1:0]    dvd_r;
  logic [13:0]                   rem_r, rem_v;
  logic [14:0]                   trial;
  logic [nsrb_pkg::DIV_BITS-1:0] qb;
  logic [nsrb_pkg::QUO_W-1:0]    quo_r;
  logic [nsrb_pkg::SUM_W-1:0]    sum;
  logic [31:0]                   disp;

  assign in_ready = (state_r == F_IDLE);
  assign accept   = in_valid && in_ready;

  // Classify the request
  assign rx_ntp = in_rx_seconds + nsrb_pkg::EPOCH_OFFSET;
  assign mode   = in_header_byte[2:0];
  assign drop   = (in_packet_length < nsrb_pkg::MIN_LEN)
               || ((mode != nsrb_pkg::MODE_CLIENT) && (mode != nsrb_pkg::MODE_SYM_ACTIVE))
               || !in_time_valid
               || (rx_ntp < nsrb_pkg::Y2020_NTP);
  assign version_in = (in_header_byte[5:3] < nsrb_pkg::VN_FLOOR) ? nsrb_pkg::VN_FLOOR
                                                                  : in_header_byte[5:3];

  // Millisecond to fraction, kept modulo 2^32
  assign rx_prod = {23'd0, in_rx_millis} * {10'd0, nsrb_pkg::MS_TO_FRAC};
  assign tx_prod = {23'd0, in_tx_millis} * {10'd0, nsrb_pkg::MS_TO_FRAC};

  // Capture the transaction fields
  always_ff @(posedge clk) begin
    if (accept) begin
      version_r   <= version_in;
      poll_r      <= in_poll_byte;
      orig_r      <= in_client_transmit_stamp;
      rx_ntp_r    <= rx_ntp;
      tx_ntp_r    <= in_tx_seconds + nsrb_pkg::EPOCH_OFFSET;
      rx_frac_r   <= rx_prod[31:0];
      tx_frac_r   <= tx_prod[31:0];
      age_r       <= in_rx_seconds - cfg.last_sync;
      use_drift_r <= (cfg.last_sync != 32'd0) && (in_rx_seconds > cfg.last_sync);
    end
  end

  // Drift product, registered into the dividend shifted left by ten bits
  assign prod = {10'd0, age_r} * {32'd0, cfg.drift};

  // Resolve several quotient bits per cycle against the constant divisor
  always_comb begin
    rem_v = rem_r;
    qb    = '0;
    trial = '0;
    for (int i = 0; i < nsrb_pkg::DIV_BITS; i++) begin
      trial = {rem_v, dvd_r[nsrb_pkg::DVD_W-1-i]};
      if (trial >= {1'b0, nsrb_pkg::DISP_DIVISOR}) begin
        rem_v = 14'(trial - {1'b0, nsrb_pkg::DISP_DIVISOR});
        qb[nsrb_pkg::DIV_BITS-1-i] = 1'b1;
      end else begin
        rem_v = trial[13:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == F_MUL) begin
      dvd_r <= {2'b00, prod, 10'd0};
      rem_r <= '0;
      quo_r <= '0;
    end else if (state_r == F_DIV) begin
      dvd_r <= {dvd_r[nsrb_pkg::DVD_W-nsrb_pkg::DIV_BITS-1:0], {nsrb_pkg::DIV_BITS{1'b0}}};
      rem_r <= rem_v;
      quo_r <= {quo_r[nsrb_pkg::QUO_W-nsrb_pkg::DIV_BITS-1:0], qb};
    end
  end

  // Add drift to the base dispersion when drift applies, and saturate at the maximum
  assign sum  = {8'd0, cfg.min_disp} + {1'b0, quo_r};
  assign disp = !use_drift_r ? cfg.min_disp
              : (sum > {8'd0, cfg.max_disp}) ? cfg.max_disp : sum[31:0];

  assign push_valid          = (state_r == F_SUM);
  assign push_data.version   = version_r;
  assign push_data.poll      = poll_r;
  assign push_data.root_disp = disp;
  assign push_data.orig      = orig_r;
  assign push_data.rx_ntp    = rx_ntp_r;
  assign push_data.rx_frac   = rx_frac_r;
  assign push_data.tx_ntp    = tx_ntp_r;
  assign push_data.tx_frac   = tx_frac_r;

  // Sequence one transaction
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept && !drop) begin
          state_nxt = F_MUL;
        end
      end
      F_MUL: begin
        state_nxt = F_DIV;
        cnt_nxt   = '0;
      end
      F_DIV: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'(nsrb_pkg::DIV_STEPS - 1)) begin
          state_nxt = F_SUM;
        end
      end
      F_SUM: begin
        if (push_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/nsrb_queue.sv
`default_nettype none

module nsrb_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire nsrb_pkg::resp_t push_data,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output nsrb_pkg::resp_t      pop_data
);

  nsrb_pkg::resp_t slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store the incoming transaction
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/nsrb_back.sv
`default_nettype none

module nsrb_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire nsrb_pkg::cfg_t  cfg,
  input  wire logic            pop_valid,
  output logic                 pop_ready,
  input  wire nsrb_pkg::resp_t pop_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [31:0]          out_word_value,
  output logic [3:0]           out_word_index,
  output logic                 out_last_word
);

  logic [3:0]  idx_r, idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] value_r;
  logic [3:0]  index_r;
  logic        last_r;
  logic        load, is_last;
  logic [31:0] word;

  assign load      = pop_valid && (!out_valid_r || out_ready);
  assign is_last   = (idx_r == nsrb_pkg::LAST_IDX);
  assign pop_ready = load && is_last;

  // Select the response word for the current position
  always_comb begin
    case (idx_r)
      nsrb_pkg::W_HEADER:     word = {cfg.leap, pop_data.version, nsrb_pkg::MODE_SERVER,
                                      cfg.stratum, pop_data.poll, nsrb_pkg::PRECISION};
      nsrb_pkg::W_ROOT_DELAY: word = 32'd0;
      nsrb_pkg::W_ROOT_DISP:  word = pop_data.root_disp;
      nsrb_pkg::W_REF_ID:     word = cfg.ref_id;
      nsrb_pkg::W_REF_SEC:    word = (cfg.last_sync != 32'd0)
                                     ? cfg.last_sync + nsrb_pkg::EPOCH_OFFSET
                                     : pop_data.rx_ntp;
      nsrb_pkg::W_REF_FRAC:   word = 32'd0;
      nsrb_pkg::W_ORIG_SEC:   word = pop_data.orig[63:32];
      nsrb_pkg::W_ORIG_FRAC:  word = pop_data.orig[31:0];
      nsrb_pkg::W_RX_SEC:     word = pop_data.rx_ntp;
      nsrb_pkg::W_RX_FRAC:    word = pop_data.rx_frac;
      nsrb_pkg::W_TX_SEC:     word = pop_data.tx_ntp;
      nsrb_pkg::W_TX_FRAC:    word = pop_data.tx_frac;
      default:                word = 32'd0;
    endcase
  end

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      idx_nxt       = is_last ? 4'd0 : idx_r + 4'd1;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Hold the output word until taken
  always_ff @(posedge clk) begin
    if (load) begin
      value_r <= word;
      index_r <= idx_r;
      last_r  <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_word_value = value_r;
  assign out_word_index = index_r;
  assign out_last_word  = last_r;

endmodule

`default_nettype wire

FILE: design/ntp_server_response_builder_top.sv
`default_nettype none

// Channel  Direction  Handshake            Content
// in_      input      in_valid/in_ready    one parsed request with clock snapshots
// out_     output     out_valid/out_ready  twelve response words per kept request
// cfg_     input      cfg_valid/cfg_ready  register index and write data
//
// A kept request passes the front in order: capture, drift multiply, the
// divider steps at six quotient bits each, saturating add; the front takes the
// next request only after pushing it. The back emits one word per cycle while
// out_ready is high. A dropped request is discarded in its accept cycle. Reset
// is synchronous, active low, and restores the register defaults. A two-entry
// queue lets the front keep accepting while the output stalls.

module ntp_server_response_builder_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [10:0] in_packet_length,
  input  wire logic [7:0]  in_header_byte,
  input  wire logic [7:0]  in_poll_byte,
  input  wire logic [63:0] in_client_transmit_stamp,
  input  wire logic        in_time_valid,
  input  wire logic [31:0] in_rx_seconds,
  input  wire logic [9:0]  in_rx_millis,
  input  wire logic [31:0] in_tx_seconds,
  input  wire logic [9:0]  in_tx_millis,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_word_value,
  output logic [3:0]       out_word_index,
  output logic             out_last_word,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  nsrb_pkg::cfg_t  cfg_r;
  logic            push_valid, push_ready, pop_valid, pop_ready;
  nsrb_pkg::resp_t push_data, pop_data;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stratum   <= 8'd1;
      cfg_r.ref_id    <= 32'd1465341506;
      cfg_r.leap      <= 2'd0;
      cfg_r.last_sync <= 32'd0;
      cfg_r.min_disp  <= 32'd655;
      cfg_r.max_disp  <= 32'd65536;
      cfg_r.drift     <= 10'd2;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        nsrb_pkg::CFG_STRATUM:   cfg_r.stratum   <= cfg_data[7:0];
        nsrb_pkg::CFG_REF_ID:    cfg_r.ref_id    <= cfg_data;
        nsrb_pkg::CFG_LEAP:      cfg_r.leap      <= cfg_data[1:0];
        nsrb_pkg::CFG_LAST_SYNC: cfg_r.last_sync <= cfg_data;
        nsrb_pkg::CFG_MIN_DISP:  cfg_r.min_disp  <= cfg_data;
        nsrb_pkg::CFG_MAX_DISP:  cfg_r.max_disp  <= cfg_data;
        nsrb_pkg::CFG_DRIFT:     cfg_r.drift     <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  nsrb_front u_front (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cfg                      (cfg_r),
    .in_valid                 (in_valid),
    .in_ready                 (in_ready),
    .in_packet_length         (in_packet_length),
    .in_header_byte           (in_header_byte),
    .in_poll_byte             (in_poll_byte),
    .in_client_transmit_stamp (in_client_transmit_stamp),
    .in_time_valid            (in_time_valid),
    .in_rx_seconds            (in_rx_seconds),
    .in_rx_millis             (in_rx_millis),
    .in_tx_seconds            (in_tx_seconds),
    .in_tx_millis             (in_tx_millis),
    .push_valid               (push_valid),
    .push_ready               (push_ready),
    .push_data                (push_data)
  );

  nsrb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  nsrb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_data       (pop_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_word_value (out_word_value),
    .out_word_index (out_word_index),
    .out_last_word  (out_last_word)
  );

endmodule

`default_nettype wire

FILE: design/nsrb_checker.sv
`default_nettype none

module nsrb_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_word_value,
  input wire logic [3:0]  out_word_index,
  input wire logic        out_last_word
);

  // Hold a stalled word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word_value)
                                && $stable(out_word_index))
    else $error("output word changed while stalled");

  // Flag the end of the response on the last position only
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == nsrb_pkg::LAST_IDX)))
    else $error("last_word does not match word_index");

  // Stream a response without gaps once started
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_word |=>
      out_valid && (out_word_index == $past(out_word_index) + 4'd1))
    else $error("response words out of sequence");

  // Server mode, precision and a version of at least the floor in the header word
  a_header: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word_index == nsrb_pkg::W_HEADER) |->
      (out_word_value[26:24] == nsrb_pkg::MODE_SERVER)
      && (out_word_value[7:0] == nsrb_pkg::PRECISION)
      && (out_word_value[29:27] >= nsrb_pkg::VN_FLOOR))
    else $error("bad header word");

endmodule

bind ntp_server_response_builder_top nsrb_checker u_nsrb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_word_value (out_word_value),
  .out_word_index (out_word_index),
  .out_last_word  (out_last_word)
);

`default_nettype wire
